// ===== rtl/bsmf_pkg.sv =====
package bsmf_pkg;

  localparam int DEF_MAX_BOLO   = 256;
  localparam int DEF_MAX_SLICES = 256;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int CFG_W = 9;

  localparam logic [1:0] CFG_FILL_MODE   = 2'd0;
  localparam logic [1:0] CFG_BOLO_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SLICE_COUNT = 2'd2;

  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_MEAN = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOT_DONE = 2'd1;
  localparam logic [1:0] STAT_NO_GOOD  = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

endpackage

// ===== rtl/bsmf_div.sv =====
module bsmf_div #(
  parameter int N = 59,
  parameter int D = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  q_r;
  logic [D-1:0]  rem_r;
  logic [D-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [D:0]    sh;
  logic [D:0]    diff;
  logic          ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh   = {rem_r, q_r[N-1]};
    ge   = sh >= {1'b0, dvs_r};
    diff = sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[D-1:0] : sh[D-1:0];
      q_r   <= {q_r[N-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/bad_sample_mean_fill_core.sv =====
// load: one word per cycle while the output is not held; a slice end with good samples
//   stalls input for the slice mean division
// fill pass after the last load: scans the slices and runs one division per
//   interpolated slice, all in the mean memory
// fetch: result registered from the sample memory read via S_RDWAIT; next fetch in S_READ
// reset: synchronous; clears control, slice valid bits; config to defaults; memories not reset
module bad_sample_mean_fill_core
  import bsmf_pkg::*;
#(
  parameter int MAX_BOLO   = DEF_MAX_BOLO,
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_sample_bad,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_bad,
  output logic               out_last_item,
  output logic [1:0]         out_result_status
);

  localparam int CNT_W  = $clog2(MAX_BOLO + 1);
  localparam int SL_W   = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int SC_W   = $clog2(MAX_SLICES + 1);
  localparam int DEPTH  = MAX_BOLO * MAX_SLICES;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOT_W  = CNT_W + SC_W;
  localparam int SUM_W  = 32 + $clog2(MAX_BOLO);
  localparam int MEAN_W = 33 + FRAC_BITS;
  localparam int MAG_W  = MEAN_W + 1;
  localparam int ACC_W  = MAG_W + SC_W;
  localparam int DIV_N  = (ACC_W > SUM_W + FRAC_BITS) ? ACC_W : SUM_W + FRAC_BITS;
  localparam int DIV_D  = (CNT_W > SC_W) ? CNT_W : SC_W;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_MDIV   = 4'd1;
  localparam logic [3:0] S_FIND   = 4'd2;
  localparam logic [3:0] S_CAPF   = 4'd3;
  localparam logic [3:0] S_LEAD   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_CAPN   = 4'd6;
  localparam logic [3:0] S_INTERP = 4'd7;
  localparam logic [3:0] S_IWAIT  = 4'd8;
  localparam logic [3:0] S_TRAIL  = 4'd9;
  localparam logic [3:0] S_READ   = 4'd10;
  localparam logic [3:0] S_RDWAIT = 4'd11;

  logic [3:0]             state_r;
  logic [1:0]             mode_r;
  logic [CFG_W-1:0]       bolo_r;
  logic [CFG_W-1:0]       slc_r;

  logic [32:0]            smem [DEPTH];
  logic [32:0]            smem_q_r;
  logic signed [MEAN_W-1:0] mmem [MAX_SLICES];
  logic signed [MEAN_W-1:0] mmem_q_r;
  logic [MAX_SLICES-1:0]  mvalid_r;

  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]       gcnt_r;
  logic [PTR_W-1:0]       ld_ptr_r;
  logic [CNT_W-1:0]       ld_bolo_r;
  logic [SL_W-1:0]        ld_slice_r;
  logic [SL_W-1:0]        wslice_r;
  logic                   ld_last_r;
  logic                   mneg_r;
  logic                   err_r;

  logic [SC_W-1:0]        i_r;
  logic [SC_W-1:0]        j_r;
  logic [SC_W-1:0]        prev_r;
  logic [SC_W-1:0]        gap_r;
  logic signed [MEAN_W-1:0] pval_r;
  logic signed [MEAN_W-1:0] nval_r;
  logic                   dneg_r;
  logic [MAG_W-1:0]       mag_r;
  logic [ACC_W-1:0]       acc_r;

  logic [PTR_W-1:0]       rd_ptr_r;
  logic [CNT_W-1:0]       rd_bolo_r;
  logic [SL_W-1:0]        rd_slice_r;
  logic                   rd_last_r;

  logic                   out_valid_r;
  logic signed [31:0]     out_value_r;
  logic                   out_bad_r;
  logic                   out_last_r;
  logic [1:0]             out_status_r;
  logic                   out_set;

  logic [CNT_W-1:0]       nb_eff;
  logic [SC_W-1:0]        ns_eff;
  logic [TOT_W-1:0]       total;
  logic                   in_fire;
  logic                   good;
  logic signed [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0]       cnt_add;
  logic [SUM_W-1:0]       sum_mag;
  logic                   slice_end;
  logic                   load_last;
  logic                   rd_last;
  logic                   rd_wrap;

  logic                   div_start;
  logic [DIV_N-1:0]       div_dvd;
  logic [DIV_D-1:0]       div_dvs;
  logic                   div_done;
  logic [DIV_N-1:0]       div_q;
  logic signed [MEAN_W-1:0] div_qm;
  logic signed [MEAN_W-1:0] mean_new;
  logic signed [MEAN_W-1:0] interp_val;
  logic signed [MAG_W-1:0]  diff;

  logic                   mw_en;
  logic [SL_W-1:0]        mw_addr;
  logic signed [MEAN_W-1:0] mw_data;
  logic [SL_W-1:0]        mr_addr;

  logic signed [MEAN_W-1:0] rnd;
  logic signed [MEAN_W-1:0] rep_full;

  // effective sizes
  always_comb begin
    if (bolo_r == '0) begin
      nb_eff = CNT_W'(1);
    end else if (int'(bolo_r) > MAX_BOLO) begin
      nb_eff = CNT_W'(MAX_BOLO);
    end else begin
      nb_eff = CNT_W'(bolo_r);
    end
    if (slc_r == '0) begin
      ns_eff = SC_W'(1);
    end else if (int'(slc_r) > MAX_SLICES) begin
      ns_eff = SC_W'(MAX_SLICES);
    end else begin
      ns_eff = SC_W'(slc_r);
    end
    total = TOT_W'(nb_eff) * TOT_W'(ns_eff);
  end

  assign in_ready = (state_r == S_LOAD || state_r == S_READ) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_set  = (state_r == S_LOAD && in_fire && in_op == OP_FETCH) || state_r == S_RDWAIT;

  always_comb begin
    good      = !in_sample_bad;
    sum_add   = sum_r + (good ? SUM_W'(in_sample_value) : SUM_W'(0));
    cnt_add   = gcnt_r + (good ? CNT_W'(1) : CNT_W'(0));
    sum_mag   = (sum_add < 0) ? SUM_W'(-sum_add) : SUM_W'(sum_add);
    slice_end = ((CNT_W+1)'(ld_bolo_r) + 1'b1) >= (CNT_W+1)'(nb_eff);
    load_last = (TOT_W'(ld_ptr_r) + 1'b1) >= total;
    rd_last   = (TOT_W'(rd_ptr_r) + 1'b1) >= total;
    rd_wrap   = ((CNT_W+1)'(rd_bolo_r) + 1'b1) >= (CNT_W+1)'(nb_eff);
  end

  // shared divider: slice means on load, interpolation steps in the fill pass
  always_comb begin
    div_start = 1'b0;
    div_dvd   = DIV_N'(acc_r + ACC_W'(mag_r));
    div_dvs   = DIV_D'(gap_r);
    if (state_r == S_LOAD) begin
      div_start = in_fire && in_op == OP_LOAD && slice_end && cnt_add != '0;
      div_dvd   = DIV_N'(sum_mag) << FRAC_BITS;
      div_dvs   = DIV_D'(cnt_add);
    end else if (state_r == S_INTERP) begin
      div_start = 1'b1;
    end
  end

  bsmf_div #(
    .N (DIV_N),
    .D (DIV_D)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    div_qm     = div_q[MEAN_W-1:0];
    mean_new   = mneg_r ? -div_qm : div_qm;
    interp_val = dneg_r ? pval_r - div_qm : pval_r + div_qm;
    diff       = MAG_W'(mmem_q_r) - MAG_W'(pval_r);
  end

  // mean memory port control
  always_comb begin
    mw_en   = 1'b0;
    mw_addr = j_r[SL_W-1:0];
    mw_data = pval_r;
    mr_addr = i_r[SL_W-1:0];
    unique case (state_r)
      S_MDIV: begin
        mw_en   = div_done;
        mw_addr = wslice_r;
        mw_data = mean_new;
      end
      S_LEAD, S_TRAIL: begin
        mw_en = 1'b1;
      end
      S_IWAIT: begin
        mw_en   = div_done;
        mw_data = interp_val;
      end
      S_READ: begin
        mr_addr = rd_slice_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mw_en) begin
      mmem[mw_addr] <= mw_data;
    end
    mmem_q_r <= mmem[mr_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_fire && in_op == OP_LOAD) begin
      smem[ld_ptr_r] <= {in_sample_bad, in_sample_value};
    end
    smem_q_r <= smem[rd_ptr_r];
  end

  // replacement value, mean truncated toward zero
  always_comb begin
    rnd      = MEAN_W'((MEAN_W'(1) << FRAC_BITS) - 1);
    rep_full = (mmem_q_r + ((mmem_q_r < 0) ? rnd : MEAN_W'(0))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      mode_r      <= MODE_KEEP;
      bolo_r      <= CFG_W'(256);
      slc_r       <= CFG_W'(256);
      mvalid_r    <= '0;
      sum_r       <= '0;
      gcnt_r      <= '0;
      ld_ptr_r    <= '0;
      ld_bolo_r   <= '0;
      ld_slice_r  <= '0;
      rd_ptr_r    <= '0;
      rd_bolo_r   <= '0;
      rd_slice_r  <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FILL_MODE:   mode_r <= cfg_wdata[1:0];
          CFG_BOLO_COUNT:  bolo_r <= cfg_wdata;
          CFG_SLICE_COUNT: slc_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_fire && in_op == OP_FETCH) begin
            out_value_r  <= '0;
            out_bad_r    <= 1'b0;
            out_last_r   <= 1'b0;
            out_status_r <= STAT_NOT_DONE;
          end else if (in_fire) begin
            if (!load_last) begin
              ld_ptr_r <= ld_ptr_r + 1'b1;
            end
            if (slice_end) begin
              sum_r      <= '0;
              gcnt_r     <= '0;
              ld_bolo_r  <= '0;
              ld_slice_r <= ld_slice_r + 1'b1;
              wslice_r   <= ld_slice_r;
              mneg_r     <= sum_add < 0;
              ld_last_r  <= load_last;
              if (cnt_add == '0) begin
                mvalid_r[ld_slice_r] <= 1'b0;
              end
            end else begin
              sum_r     <= sum_add;
              gcnt_r    <= cnt_add;
              ld_bolo_r <= ld_bolo_r + 1'b1;
            end
            if (slice_end && cnt_add != '0) begin
              state_r <= S_MDIV;
            end else if (load_last) begin
              i_r     <= '0;
              state_r <= S_FIND;
            end
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mvalid_r[wslice_r] <= 1'b1;
            if (ld_last_r) begin
              i_r     <= '0;
              state_r <= S_FIND;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_FIND: begin
          if (mvalid_r[i_r[SL_W-1:0]]) begin
            prev_r  <= i_r;
            state_r <= S_CAPF;
          end else if (i_r + 1'b1 >= ns_eff) begin
            err_r   <= 1'b1;
            state_r <= S_READ;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_CAPF: begin
          pval_r  <= mmem_q_r;
          j_r     <= '0;
          i_r     <= prev_r + 1'b1;
          state_r <= (prev_r == '0) ? S_SCAN : S_LEAD;
        end
        S_LEAD: begin
          if (j_r + 1'b1 == prev_r) begin
            state_r <= S_SCAN;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (i_r >= ns_eff) begin
            if (prev_r + 1'b1 >= ns_eff) begin
              state_r <= S_READ;
            end else begin
              j_r     <= prev_r + 1'b1;
              state_r <= S_TRAIL;
            end
          end else if (mvalid_r[i_r[SL_W-1:0]]) begin
            state_r <= S_CAPN;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_CAPN: begin
          nval_r <= mmem_q_r;
          dneg_r <= diff < 0;
          mag_r  <= (diff < 0) ? MAG_W'(-diff) : MAG_W'(diff);
          gap_r  <= i_r - prev_r;
          acc_r  <= '0;
          j_r    <= prev_r + 1'b1;
          if (i_r == prev_r + 1'b1) begin
            prev_r  <= i_r;
            pval_r  <= mmem_q_r;
            i_r     <= i_r + 1'b1;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_INTERP;
          end
        end
        S_INTERP: begin
          acc_r   <= acc_r + ACC_W'(mag_r);
          state_r <= S_IWAIT;
        end
        S_IWAIT: begin
          if (div_done) begin
            if (j_r + 1'b1 == i_r) begin
              prev_r  <= i_r;
              pval_r  <= nval_r;
              i_r     <= i_r + 1'b1;
              state_r <= S_SCAN;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_INTERP;
            end
          end
        end
        S_TRAIL: begin
          if (j_r + 1'b1 >= ns_eff) begin
            state_r <= S_READ;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_READ: begin
          if (in_fire && in_op == OP_FETCH) begin
            rd_last_r <= rd_last;
            if (!rd_last) begin
              rd_ptr_r <= rd_ptr_r + 1'b1;
              if (rd_wrap) begin
                rd_bolo_r  <= '0;
                rd_slice_r <= rd_slice_r + 1'b1;
              end else begin
                rd_bolo_r <= rd_bolo_r + 1'b1;
              end
            end
            state_r <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          out_last_r <= rd_last_r;
          if (mode_r == MODE_MEAN && err_r) begin
            out_status_r <= STAT_NO_GOOD;
            out_value_r  <= '0;
            out_bad_r    <= 1'b0;
          end else begin
            out_status_r <= STAT_OK;
            if (!smem_q_r[32]) begin
              out_value_r <= smem_q_r[31:0];
              out_bad_r   <= 1'b0;
            end else begin
              case (mode_r)
                MODE_ZERO: begin
                  out_value_r <= '0;
                  out_bad_r   <= 1'b0;
                end
                MODE_MEAN: begin
                  out_value_r <= rep_full[31:0];
                  out_bad_r   <= 1'b0;
                end
                default: begin
                  out_value_r <= smem_q_r[31:0];
                  out_bad_r   <= 1'b1;
                end
              endcase
            end
          end
          if (rd_last_r) begin
            mvalid_r   <= '0;
            sum_r      <= '0;
            gcnt_r     <= '0;
            ld_ptr_r   <= '0;
            ld_bolo_r  <= '0;
            ld_slice_r <= '0;
            rd_ptr_r   <= '0;
            rd_bolo_r  <= '0;
            rd_slice_r <= '0;
            err_r      <= 1'b0;
            state_r    <= S_LOAD;
          end else begin
            state_r <= S_READ;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = out_value_r;
  assign out_bad           = out_bad_r;
  assign out_last_item     = out_last_r;
  assign out_result_status = out_status_r;

endmodule
